[design/sdpf_pkg.sv]
// shared widths, limits and defaults of the soft-disk pair force block
package sdpf_pkg;

  localparam int unsigned DEF_MAX_NEIGHBORS = 1024;
  localparam int unsigned DEF_FRAC_BITS     = 16;
  localparam int unsigned DEF_POS_WIDTH     = 32;

  localparam int unsigned BOX_W   = 32;
  localparam int unsigned RAD_W   = 24;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;

  localparam int unsigned RSUM_W = RAD_W + 1;
  localparam int unsigned PROD_W = 2 * RSUM_W;
  localparam int unsigned SQ_W   = PROD_W + 2;
  localparam int unsigned ROOT_W = RSUM_W + 1;
  localparam int unsigned UNIT_W = RSUM_W + 5;
  localparam int unsigned ITER_W = $clog2(PROD_W);

  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(65536);

  localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]        UMAX = {SUM_W{1'b1}};

endpackage

[design/sdpf_pair_if.sv]
// pair input channel: both positions and radii plus the last flag
interface sdpf_pair_if #(
  parameter int unsigned POS_WIDTH = sdpf_pkg::DEF_POS_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [POS_WIDTH-1:0]        particle_x;
  logic [POS_WIDTH-1:0]        particle_y;
  logic [sdpf_pkg::RAD_W-1:0]  particle_radius;
  logic [POS_WIDTH-1:0]        neighbor_x;
  logic [POS_WIDTH-1:0]        neighbor_y;
  logic [sdpf_pkg::RAD_W-1:0]  neighbor_radius;
  logic                        last;

  modport source (
    output valid, particle_x, particle_y, particle_radius,
    output neighbor_x, neighbor_y, neighbor_radius, last,
    input  ready
  );
  modport sink (
    input  valid, particle_x, particle_y, particle_radius,
    input  neighbor_x, neighbor_y, neighbor_radius, last,
    output ready
  );
endinterface

[design/sdpf_sum_if.sv]
// per-particle sum output channel
interface sdpf_sum_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdpf_pkg::SUM_W-1:0] force_x;
  logic signed [sdpf_pkg::SUM_W-1:0] force_y;
  logic [sdpf_pkg::SUM_W-1:0]        energy;
  logic [sdpf_pkg::SUM_W-1:0]        virial;
  logic [sdpf_pkg::CNT_W-1:0]        contacts;

  modport source (
    output valid, force_x, force_y, energy, virial, contacts,
    input  ready
  );
  modport sink (
    input  valid, force_x, force_y, energy, virial, contacts,
    output ready
  );
endinterface

[design/soft_disk_pair_force.sv]
// soft-disk harmonic pair force accumulator, top level
//
//  channel     dir  beat                              when taken
//  pair_in     in   two positions, two radii, last    valid & ready
//  sum_out     out  force x/y, energy, virial, count  valid & ready
//  box_length  in   box side, Q16.16                  box_length_we_i
//
//  a far pair skips straight from the bounds check to the end: one shared
//  compare-subtract unit runs the 26-step square root and two 50-step
//  divisions, one shared multiplier forms all six products
//  rst_ni clears the sums and the control, box length resets to 1.0
//  one pair at a time; a finished sum waits in the output register and
//  stalls the block only when the next last beat is due before it is taken
module soft_disk_pair_force #(
  parameter int unsigned MAX_NEIGHBORS = sdpf_pkg::DEF_MAX_NEIGHBORS,
  parameter int unsigned FRAC_BITS     = sdpf_pkg::DEF_FRAC_BITS,
  parameter int unsigned POS_WIDTH     = sdpf_pkg::DEF_POS_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       box_length_we_i,
  input  logic [sdpf_pkg::BOX_W-1:0] box_length_i,
  sdpf_pair_if.sink                  pair_in,
  sdpf_sum_if.source                 sum_out
);

  localparam int unsigned BOX_W  = sdpf_pkg::BOX_W;
  localparam int unsigned RSUM_W = sdpf_pkg::RSUM_W;
  localparam int unsigned PROD_W = sdpf_pkg::PROD_W;
  localparam int unsigned SQ_W   = sdpf_pkg::SQ_W;
  localparam int unsigned ROOT_W = sdpf_pkg::ROOT_W;
  localparam int unsigned UNIT_W = sdpf_pkg::UNIT_W;
  localparam int unsigned ITER_W = sdpf_pkg::ITER_W;
  localparam int unsigned SUM_W  = sdpf_pkg::SUM_W;
  localparam int unsigned CNT_W  = sdpf_pkg::CNT_W;
  localparam int unsigned WW     = ((POS_WIDTH > BOX_W) ? POS_WIDTH : BOX_W) + 3;
  localparam int unsigned FW     = PROD_W + 2;
  localparam int unsigned EW     = PROD_W + 1;
  localparam int unsigned ESH    = FRAC_BITS + 1;

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'((MAX_NEIGHBORS < sdpf_pkg::CNT_MAX) ?
                                                MAX_NEIGHBORS : sdpf_pkg::CNT_MAX);
  localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQ_W / 2 - 1);
  localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(PROD_W - 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIFF = 5'd1;
  localparam logic [4:0] S_WRAP = 5'd2;
  localparam logic [4:0] S_FAR  = 5'd3;
  localparam logic [4:0] S_MX   = 5'd4;
  localparam logic [4:0] S_MY   = 5'd5;
  localparam logic [4:0] S_SUM  = 5'd6;
  localparam logic [4:0] S_SQRT = 5'd7;
  localparam logic [4:0] S_CHK  = 5'd8;
  localparam logic [4:0] S_MOO  = 5'd9;
  localparam logic [4:0] S_EN   = 5'd10;
  localparam logic [4:0] S_VIR  = 5'd11;
  localparam logic [4:0] S_LDX  = 5'd12;
  localparam logic [4:0] S_DIVX = 5'd13;
  localparam logic [4:0] S_FX   = 5'd14;
  localparam logic [4:0] S_LDY  = 5'd15;
  localparam logic [4:0] S_DIVY = 5'd16;
  localparam logic [4:0] S_FY   = 5'd17;
  localparam logic [4:0] S_FIN  = 5'd18;

  function automatic logic signed [SUM_W-1:0] sat_force(
    input logic signed [SUM_W-1:0] acc,
    input logic [PROD_W-1:0]       mag,
    input logic                    neg
  );
    logic signed [FW-1:0] add;
    logic signed [FW-1:0] s;
    add = signed'(FW'(mag));
    if (neg) begin
      add = -add;
    end
    s = FW'(acc) + add;
    if (s > FW'(sdpf_pkg::SMAX)) begin
      return sdpf_pkg::SMAX;
    end else if (s < FW'(sdpf_pkg::SMIN)) begin
      return sdpf_pkg::SMIN;
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_acc(
    input logic [SUM_W-1:0]  acc,
    input logic [PROD_W-1:0] add
  );
    logic [EW-1:0] s;
    s = EW'(acc) + EW'(add);
    return (s > EW'(sdpf_pkg::UMAX)) ? sdpf_pkg::UMAX : s[SUM_W-1:0];
  endfunction

  // control
  logic [4:0]        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;
  logic [BOX_W-1:0]  box_q, box_d;
  logic signed [SUM_W-1:0] fx_q, fx_d, fy_q, fy_d;
  logic [SUM_W-1:0]  en_q, en_d, vir_q, vir_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // datapath
  logic [POS_WIDTH-1:0]  px_q, px_d, py_q, py_d, nx_q, nx_d, ny_q, ny_d;
  logic [RSUM_W-1:0]     rsum_q, rsum_d;
  logic                  last_q, last_d;
  logic signed [WW-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [RSUM_W-1:0]     adx_q, adx_d, ady_q, ady_d;
  logic                  sx_q, sx_d, sy_q, sy_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [SQ_W-1:0]       work_q, work_d;
  logic [UNIT_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [RSUM_W-1:0]     o_q, o_d, dist_q, dist_d;
  logic signed [SUM_W-1:0] ofx_q, ofx_d, ofy_q, ofy_d;
  logic [SUM_W-1:0]      oen_q, oen_d, ovir_q, ovir_d;
  logic [CNT_W-1:0]      ocnt_q, ocnt_d;

  // shared units
  logic [RSUM_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              in_sqrt;
  logic [UNIT_W-1:0] unit_a, unit_b;
  logic [UNIT_W:0]   unit_diff;
  logic              unit_ge;

  logic signed [WW-1:0] len_s, dx2, dy2, wdx, wdy;
  logic [WW-1:0]        adx_full, ady_full, rsum_ext;
  logic                 pair_take, out_take;

  assign pair_take = pair_in.valid && pair_in.ready;
  assign out_take  = sum_out.valid && sum_out.ready;

  always_comb begin
    unique case (state_q)
      S_MX:    begin mul_a = adx_q;  mul_b = adx_q; end
      S_MY:    begin mul_a = ady_q;  mul_b = ady_q; end
      S_MOO:   begin mul_a = o_q;    mul_b = o_q;   end
      S_EN:    begin mul_a = dist_q; mul_b = o_q;   end
      S_VIR:   begin mul_a = o_q;    mul_b = adx_q; end
      S_LDX:   begin mul_a = o_q;    mul_b = ady_q; end
      default: begin mul_a = '0;     mul_b = '0;    end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // compare-subtract unit shared by square root and division
  assign in_sqrt = (state_q == S_SQRT);
  assign unit_a  = in_sqrt ? {rem_q[UNIT_W-3:0], work_q[SQ_W-1 -: 2]}
                           : {rem_q[UNIT_W-2:0], work_q[PROD_W-1]};
  assign unit_b  = in_sqrt ? UNIT_W'({root_q, 2'b01}) : UNIT_W'(dist_q);
  assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_ge   = !unit_diff[UNIT_W];

  // minimum image, one wrap
  always_comb begin
    len_s = signed'(WW'(box_q));
    dx2   = dx_q <<< 1;
    dy2   = dy_q <<< 1;
    priority if (dx2 > len_s) begin
      wdx = dx_q - len_s;
    end else if (dx2 < -len_s) begin
      wdx = dx_q + len_s;
    end else begin
      wdx = dx_q;
    end
    priority if (dy2 > len_s) begin
      wdy = dy_q - len_s;
    end else if (dy2 < -len_s) begin
      wdy = dy_q + len_s;
    end else begin
      wdy = dy_q;
    end
    adx_full = dx_q[WW-1] ? WW'(-dx_q) : WW'(dx_q);
    ady_full = dy_q[WW-1] ? WW'(-dy_q) : WW'(dy_q);
    rsum_ext = WW'(rsum_q);
  end

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q;
    box_d       = box_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    en_d        = en_q;
    vir_d       = vir_q;
    cnt_d       = cnt_q;
    px_d        = px_q;
    py_d        = py_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    rsum_d      = rsum_q;
    last_d      = last_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    adx_d       = adx_q;
    ady_d       = ady_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    prod_d      = prod_q;
    work_d      = work_q;
    rem_d       = rem_q;
    root_d      = root_q;
    o_d         = o_q;
    dist_d      = dist_q;
    ofx_d       = ofx_q;
    ofy_d       = ofy_q;
    oen_d       = oen_q;
    ovir_d      = ovir_q;
    ocnt_d      = ocnt_q;

    if (box_length_we_i) begin
      box_d = box_length_i;
    end
    if (out_take) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (pair_take) begin
          px_d    = pair_in.particle_x;
          py_d    = pair_in.particle_y;
          nx_d    = pair_in.neighbor_x;
          ny_d    = pair_in.neighbor_y;
          rsum_d  = RSUM_W'(pair_in.particle_radius) + RSUM_W'(pair_in.neighbor_radius);
          last_d  = pair_in.last;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        dx_d    = signed'(WW'(px_q)) - signed'(WW'(nx_q));
        dy_d    = signed'(WW'(py_q)) - signed'(WW'(ny_q));
        state_d = S_WRAP;
      end
      S_WRAP: begin
        dx_d    = wdx;
        dy_d    = wdy;
        state_d = S_FAR;
      end
      S_FAR: begin
        adx_d = adx_full[RSUM_W-1:0];
        ady_d = ady_full[RSUM_W-1:0];
        sx_d  = dx_q[WW-1];
        sy_d  = dy_q[WW-1];
        if (adx_full < rsum_ext && ady_full < rsum_ext) begin
          state_d = S_MX;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MX: begin
        prod_d  = mul_p;
        state_d = S_MY;
      end
      S_MY: begin
        work_d  = SQ_W'(prod_q);
        prod_d  = mul_p;
        state_d = S_SUM;
      end
      S_SUM: begin
        work_d  = work_q + SQ_W'(prod_q);
        rem_d   = '0;
        root_d  = '0;
        iter_d  = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        rem_d  = unit_ge ? unit_diff[UNIT_W-1:0] : unit_a;
        root_d = {root_q[ROOT_W-2:0], unit_ge};
        work_d = work_q << 2;
        iter_d = iter_q + 1'b1;
        if (iter_q == SQRT_LAST) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        o_d    = rsum_q - root_q[RSUM_W-1:0];
        dist_d = root_q[RSUM_W-1:0];
        if (root_q >= ROOT_W'(rsum_q)) begin
          state_d = S_FIN;
        end else begin
          if (cnt_q < CNT_CAP) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = S_MOO;
        end
      end
      S_MOO: begin
        prod_d  = mul_p;
        state_d = S_EN;
      end
      S_EN: begin
        en_d    = sat_acc(en_q, prod_q >> ESH);
        prod_d  = mul_p;
        state_d = S_VIR;
      end
      S_VIR: begin
        vir_d  = sat_acc(vir_q, prod_q >> FRAC_BITS);
        prod_d = mul_p;
        if (dist_q == '0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_LDX;
        end
      end
      S_LDX, S_LDY: begin
        work_d  = SQ_W'(prod_q);
        rem_d   = '0;
        iter_d  = '0;
        prod_d  = mul_p;
        state_d = (state_q == S_LDX) ? S_DIVX : S_DIVY;
      end
      S_DIVX, S_DIVY: begin
        rem_d  = unit_ge ? unit_diff[UNIT_W-1:0] : unit_a;
        work_d = {work_q[SQ_W-2:0], unit_ge};
        iter_d = iter_q + 1'b1;
        if (iter_q == DIV_LAST) begin
          state_d = (state_q == S_DIVX) ? S_FX : S_FY;
        end
      end
      S_FX: begin
        fx_d    = sat_force(fx_q, work_q[PROD_W-1:0], sx_q);
        state_d = S_LDY;
      end
      S_FY: begin
        fy_d    = sat_force(fy_q, work_q[PROD_W-1:0], sy_q);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || sum_out.ready) begin
          ofx_d       = fx_q;
          ofy_d       = fy_q;
          oen_d       = en_q;
          ovir_d      = vir_q;
          ocnt_d      = cnt_q;
          out_valid_d = 1'b1;
          fx_d        = '0;
          fy_d        = '0;
          en_d        = '0;
          vir_d       = '0;
          cnt_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      box_q       <= sdpf_pkg::BOX_RESET;
      fx_q        <= '0;
      fy_q        <= '0;
      en_q        <= '0;
      vir_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
      box_q       <= box_d;
      fx_q        <= fx_d;
      fy_q        <= fy_d;
      en_q        <= en_d;
      vir_q       <= vir_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    rsum_q <= rsum_d;
    last_q <= last_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    adx_q  <= adx_d;
    ady_q  <= ady_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    prod_q <= prod_d;
    work_q <= work_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    o_q    <= o_d;
    dist_q <= dist_d;
    ofx_q  <= ofx_d;
    ofy_q  <= ofy_d;
    oen_q  <= oen_d;
    ovir_q <= ovir_d;
    ocnt_q <= ocnt_d;
  end

  assign pair_in.ready    = (state_q == S_IDLE);
  assign sum_out.valid    = out_valid_q;
  assign sum_out.force_x  = ofx_q;
  assign sum_out.force_y  = ofy_q;
  assign sum_out.energy   = oen_q;
  assign sum_out.virial   = ovir_q;
  assign sum_out.contacts = ocnt_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_take |=> !pair_in.ready)
    else $error("pair taken while a pair is still in work");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_out.valid |-> (sum_out.contacts <= CNT_CAP))
    else $error("contact count beyond its cap");

  a_emit_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sum_out.valid) |-> $past(state_q == S_FIN && last_q))
    else $error("sum beat raised without a last pair");

endmodule

[test/tb_soft_disk_pair_force.sv]
// testbench for soft_disk_pair_force: directed table then random pairs, checked by a predictor or typed sums
module tb_soft_disk_pair_force;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = sdpf_pkg::DEF_FRAC_BITS;
  localparam int unsigned CONTACT_CAP = (sdpf_pkg::DEF_MAX_NEIGHBORS < sdpf_pkg::CNT_MAX) ?
                                        sdpf_pkg::DEF_MAX_NEIGHBORS : sdpf_pkg::CNT_MAX;
  localparam longint SMAX48 = 64'sd140737488355327;
  localparam longint SMIN48 = -64'sd140737488355328;
  localparam longint UMAX48 = 64'sd281474976710655;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 20;
  localparam int unsigned COUNT_RUN = 1030;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [23:0] pr;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [23:0] nr;
    logic        last;
  } pair_t;

  typedef struct packed {
    logic signed [sdpf_pkg::SUM_W-1:0] fx;
    logic signed [sdpf_pkg::SUM_W-1:0] fy;
    logic [sdpf_pkg::SUM_W-1:0]        energy;
    logic [sdpf_pkg::SUM_W-1:0]        virial;
    logic [sdpf_pkg::CNT_W-1:0]        contacts;
  } sums_t;

  typedef struct packed {
    pair_t pair;
    logic  typed;
    sums_t want;
  } dir_row_t;

  localparam sums_t NO_SUMS = '0;
  localparam sums_t ONE_CENTRED = '{48'sd0, 48'sd0, 48'd512, 48'd0, 11'd1};

  // box is 1.0 throughout this table
  localparam int unsigned DIR_ROWS = 12;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // far pair straight after reset
    '{'{32'h0, 32'h0, 24'h1000, 32'h8000, 32'h8000, 24'h1000, 1'b1}, 1'b1, NO_SUMS},
    // coincident centres
    '{'{32'h4000, 32'h4000, 24'h1000, 32'h4000, 32'h4000, 24'h1000, 1'b1}, 1'b1, ONE_CENTRED},
    // just touching on an axis and on the diagonal
    '{'{32'h1000, 32'h0, 24'h1000, 32'h3000, 32'h0, 24'h1000, 1'b1}, 1'b1, NO_SUMS},
    '{'{32'h0, 32'h0, 24'h1000, 32'h16A1, 32'h16A1, 24'h1000, 1'b1}, 1'b1, NO_SUMS},
    // no radius at all
    '{'{32'h4000, 32'h4000, 24'h0, 32'h4000, 32'h4000, 24'h0, 1'b1}, 1'b1, NO_SUMS},
    // minimum image both ways, then a plain contact
    '{'{32'h0100, 32'h8000, 24'h1000, 32'hFF00, 32'h8000, 24'h1000, 1'b0}, 1'b0, NO_SUMS},
    '{'{32'h8000, 32'hFF00, 24'h1000, 32'h8000, 32'h0100, 24'h1000, 1'b0}, 1'b0, NO_SUMS},
    '{'{32'h2000, 32'h2000, 24'h1800, 32'h2C00, 32'h1A00, 24'h0C00, 1'b1}, 1'b0, NO_SUMS},
    // largest radii
    '{'{32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF,
        1'b0}, 1'b0, NO_SUMS},
    '{'{32'h0, 32'h0, 24'hFF_FFFF, 32'h01FF_FFFD, 32'h0, 24'hFF_FFFF, 1'b1}, 1'b0, NO_SUMS},
    // far beyond the box
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'h0, 32'h0, 24'hFF_FFFF, 1'b1}, 1'b1,
        NO_SUMS},
    '{'{32'h0, 32'hFFFF_FFFF, 24'h12_3456, 32'hFFFF_FFFF, 32'h0, 24'hAB_CDEF, 1'b1}, 1'b0,
        NO_SUMS}
  };

  localparam logic [31:0] BOX_PLAN [6] = '{
    32'd1, 32'hFFFF_FFFF, sdpf_pkg::BOX_RESET, 32'h0040_0000, 32'h0000_0100, 32'h0200_0000
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       box_length_we_i;
  logic [sdpf_pkg::BOX_W-1:0] box_length_i;

  sdpf_pair_if #(.POS_WIDTH(sdpf_pkg::DEF_POS_WIDTH)) pair_bus ();
  sdpf_sum_if sum_bus ();

  soft_disk_pair_force DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .box_length_we_i (box_length_we_i),
    .box_length_i    (box_length_i),
    .pair_in         (pair_bus),
    .sum_out         (sum_bus)
  );

  logic [31:0] box_now;
  longint      fx_acc, fy_acc, en_acc, vir_acc;
  int unsigned contacts_acc;
  sums_t       sums_due [$];
  int unsigned mismatches;
  logic        calm;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint min_image(longint d, longint len);
    if (2 * d > len) return d - len;
    if (2 * d < -len) return d + len;
    return d;
  endfunction

  function automatic longint force_share(longint o, longint d, longint sep);
    longint q;
    q = (o * (d < 0 ? -d : d)) / sep;
    return d < 0 ? -q : q;
  endfunction

  function automatic longint clamp_s48(longint v);
    if (v > SMAX48) return SMAX48;
    if (v < SMIN48) return SMIN48;
    return v;
  endfunction

  function automatic longint clamp_u48(longint v);
    return v > UMAX48 ? UMAX48 : v;
  endfunction

  function automatic longint fold_box(longint v, longint len);
    return ((v % len) + len) % len;
  endfunction

  // one pair into the running sums, hands back the sums on the last neighbour
  task automatic account_pair(input pair_t p, output logic emit, output sums_t s);
    longint px, py, nx, ny, len, rsum, dx, dy, adx, ady, sep, o;
    px = longint'(p.px);
    py = longint'(p.py);
    nx = longint'(p.nx);
    ny = longint'(p.ny);
    len = longint'(box_now);
    rsum = longint'(p.pr);
    rsum = rsum + longint'(p.nr);
    dx = min_image(px - nx, len);
    dy = min_image(py - ny, len);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (adx < rsum && ady < rsum) begin
      sep = root_floor(adx * adx + ady * ady);
      if (sep < rsum) begin
        o = rsum - sep;
        if (sep != 0) begin
          fx_acc = clamp_s48(fx_acc + force_share(o, dx, sep));
          fy_acc = clamp_s48(fy_acc + force_share(o, dy, sep));
        end
        en_acc = clamp_u48(en_acc + ((o * o) >>> (FRAC + 1)));
        vir_acc = clamp_u48(vir_acc + ((sep * o) >>> FRAC));
        if (contacts_acc < CONTACT_CAP) contacts_acc++;
      end
    end
    emit = p.last;
    s = NO_SUMS;
    if (emit) begin
      s.fx = fx_acc[47:0];
      s.fy = fy_acc[47:0];
      s.energy = en_acc[47:0];
      s.virial = vir_acc[47:0];
      s.contacts = contacts_acc[10:0];
      fx_acc = 0;
      fy_acc = 0;
      en_acc = 0;
      vir_acc = 0;
      contacts_acc = 0;
    end
  endtask

  function automatic logic [23:0] draw_radius();
    case ($urandom_range(0, 15))
      0: return '0;
      1, 2: return 24'($urandom);
      default: return 24'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  // mostly neighbours near the particle, some coincident, touching or pure noise
  function automatic pair_t draw_pair(logic [31:0] box, int unsigned last_pct);
    pair_t  p;
    longint len, rsum, span, px, py, ox, oy;
    int unsigned shape;
    len = longint'(box);
    p.pr = draw_radius();
    p.nr = draw_radius();
    rsum = longint'(p.pr);
    rsum = rsum + longint'(p.nr);
    span = rsum + rsum / 4 + 1;
    px = longint'($urandom);
    py = longint'($urandom);
    shape = $urandom_range(0, 15);
    ox = longint'($urandom_range(0, 32'(2 * span)));
    ox -= span;
    oy = longint'($urandom_range(0, 32'(2 * span)));
    oy -= span;
    if (shape == 2) begin
      ox = 0;
      oy = 0;
    end else if (shape == 3) begin
      ox = $urandom_range(0, 1) ? rsum : -rsum;
      oy = 0;
      if ($urandom_range(0, 1)) begin
        oy = ox;
        ox = 0;
      end
    end
    if (shape < 2) begin
      p.px = $urandom;
      p.py = $urandom;
      p.nx = $urandom;
      p.ny = $urandom;
    end else if (shape == 4) begin
      p.px = px[31:0];
      p.py = py[31:0];
      p.nx = 32'(px - ox);
      p.ny = 32'(py - oy);
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        px = longint'($urandom_range(0, 32'hFFFF));
        py = longint'($urandom_range(0, 32'hFFFF));
      end
      px = px % len;
      py = py % len;
      p.px = px[31:0];
      p.py = py[31:0];
      p.nx = 32'(fold_box(px - ox, len));
      p.ny = 32'(fold_box(py - oy, len));
    end
    p.last = $urandom_range(0, 99) < last_pct;
    return p;
  endfunction

  task automatic push_pair(input pair_t p, input logic typed, input sums_t typed_sums);
    sums_t due;
    logic  emit;
    while (!calm && $urandom_range(0, 99) < 30) begin
      pair_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    pair_bus.particle_x = p.px;
    pair_bus.particle_y = p.py;
    pair_bus.particle_radius = p.pr;
    pair_bus.neighbor_x = p.nx;
    pair_bus.neighbor_y = p.ny;
    pair_bus.neighbor_radius = p.nr;
    pair_bus.last = p.last;
    pair_bus.valid = 1'b1;
    do @(posedge clk_i); while (pair_bus.ready !== 1'b1);
    account_pair(p, emit, due);
    if (emit) sums_due.push_back(typed ? typed_sums : due);
    @(negedge clk_i);
  endtask

  // hold off until every sum is back and the last pair has drained
  task automatic wait_quiet();
    pair_bus.valid = 1'b0;
    while (sums_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_box(input logic [31:0] v);
    box_length_we_i = 1'b1;
    box_length_i = v;
    @(negedge clk_i);
    box_length_we_i = 1'b0;
    box_now = v;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) sum_bus.ready = calm || ($urandom_range(0, 99) >= 30);

  always @(posedge clk_i) begin
    sums_t want;
    if (rst_ni && sum_bus.valid === 1'b1 && sum_bus.ready === 1'b1) begin
      if (sums_due.size() == 0) begin
        $display("%0t: sum beat with none expected", $time);
        mismatches++;
      end else begin
        want = sums_due.pop_front();
        check_field("force_x", want.fx, sum_bus.force_x);
        check_field("force_y", want.fy, sum_bus.force_y);
        check_field("energy", want.energy, sum_bus.energy);
        check_field("virial", want.virial, sum_bus.virial);
        check_field("contacts", want.contacts, sum_bus.contacts);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    pair_t       cur;
    longint      rs, ox, oy, len;
    logic [31:0] box;
    int unsigned last_pct;
    rst_ni = 1'b0;
    box_length_we_i = 1'b0;
    box_length_i = '0;
    pair_bus.valid = 1'b0;
    pair_bus.particle_x = '0;
    pair_bus.particle_y = '0;
    pair_bus.particle_radius = '0;
    pair_bus.neighbor_x = '0;
    pair_bus.neighbor_y = '0;
    pair_bus.neighbor_radius = '0;
    pair_bus.last = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    box_now = sdpf_pkg::BOX_RESET;
    fx_acc = 0;
    fy_acc = 0;
    en_acc = 0;
    vir_acc = 0;
    contacts_acc = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      push_pair(DIR_TABLE[i].pair, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    wait_quiet();

    // contact count runs into its cap
    set_box(32'h0040_0000);
    len = longint'(box_now);
    for (int k = 0; k < COUNT_RUN; k++) begin
      cur.pr = 24'($urandom_range(32'h800, 32'h8000));
      cur.nr = 24'($urandom_range(32'h800, 32'h8000));
      rs = longint'(cur.pr);
      rs = (rs + longint'(cur.nr)) / 3;
      ox = longint'($urandom_range(0, 32'(2 * rs)));
      ox -= rs;
      oy = longint'($urandom_range(0, 32'(2 * rs)));
      oy -= rs;
      cur.px = $urandom_range(0, 32'h003F_FFFF);
      cur.py = $urandom_range(0, 32'h003F_FFFF);
      cur.nx = 32'(fold_box(longint'(cur.px) - ox, len));
      cur.ny = 32'(fold_box(longint'(cur.py) - oy, len));
      cur.last = 1'b0;
      push_pair(cur, 1'b0, NO_SUMS);
    end
    cur = '0;
    cur.last = 1'b1;
    push_pair(cur, 1'b0, NO_SUMS);
    wait_quiet();

    for (int ph = 0; ph < 8; ph++) begin
      box = (ph < 6) ? BOX_PLAN[ph] : ($urandom | 32'd1);
      last_pct = (ph == 2) ? 5 : (ph == 5) ? 60 : 25;
      calm = (ph == 3);
      set_box(box);
      for (int i = 0; i < PHASE_ITEMS; i++) push_pair(draw_pair(box, last_pct), 1'b0, NO_SUMS);
      wait_quiet();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
